// ----- rtl/mclk_pkg.sv -----
`timescale 1ns / 1ps

package mclk_pkg;

   localparam int SYMBOL_W     = 6;
   localparam int SYMBOL_COUNT = 36;
   localparam int ELEM_MAX     = 5;
   localparam int UNIT_TICKS_W = 20;
   localparam logic [UNIT_TICKS_W-1:0] UNIT_TICKS_RESET = 20'd100000;

   localparam logic CSR_UNIT_TICKS  = 1'b0;
   localparam logic CSR_FLIGHT_MODE = 1'b1;

   localparam logic [1:0] OP_NOP   = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   typedef struct packed {
      logic [2:0]          len;
      logic [ELEM_MAX-1:0] dashes;
   } morse_entry_type;

   typedef struct packed {
      logic [1:0]      op;
      morse_entry_type pattern;
   } cmd_type;

   // Bit i of dashes is set when element i of the character is a dash.
   function automatic morse_entry_type morse_lookup(input logic [SYMBOL_W-1:0] sym);
      morse_entry_type e;
      case (sym)
         6'd0:    e = '{3'd2, 5'b00010};
         6'd1:    e = '{3'd4, 5'b00001};
         6'd2:    e = '{3'd4, 5'b00101};
         6'd3:    e = '{3'd3, 5'b00001};
         6'd4:    e = '{3'd1, 5'b00000};
         6'd5:    e = '{3'd4, 5'b00100};
         6'd6:    e = '{3'd3, 5'b00011};
         6'd7:    e = '{3'd4, 5'b00000};
         6'd8:    e = '{3'd2, 5'b00000};
         6'd9:    e = '{3'd4, 5'b01110};
         6'd10:   e = '{3'd3, 5'b00101};
         6'd11:   e = '{3'd4, 5'b00010};
         6'd12:   e = '{3'd2, 5'b00011};
         6'd13:   e = '{3'd2, 5'b00001};
         6'd14:   e = '{3'd3, 5'b00111};
         6'd15:   e = '{3'd4, 5'b00110};
         6'd16:   e = '{3'd4, 5'b01011};
         6'd17:   e = '{3'd3, 5'b00010};
         6'd18:   e = '{3'd3, 5'b00000};
         6'd19:   e = '{3'd1, 5'b00001};
         6'd20:   e = '{3'd3, 5'b00100};
         6'd21:   e = '{3'd4, 5'b01000};
         6'd22:   e = '{3'd3, 5'b00110};
         6'd23:   e = '{3'd4, 5'b01001};
         6'd24:   e = '{3'd4, 5'b01101};
         6'd25:   e = '{3'd4, 5'b00011};
         6'd26:   e = '{3'd5, 5'b11110};
         6'd27:   e = '{3'd5, 5'b11100};
         6'd28:   e = '{3'd5, 5'b11000};
         6'd29:   e = '{3'd5, 5'b10000};
         6'd30:   e = '{3'd5, 5'b00000};
         6'd31:   e = '{3'd5, 5'b00001};
         6'd32:   e = '{3'd5, 5'b00011};
         6'd33:   e = '{3'd5, 5'b00111};
         6'd34:   e = '{3'd5, 5'b01111};
         6'd35:   e = '{3'd5, 5'b11111};
         default: e = '{3'd0, 5'b00000};
      endcase
      return e;
   endfunction

endpackage

// ----- rtl/mclk_front.sv -----
`timescale 1ns / 1ps

module mclk_front
   import mclk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_kind,
   input  logic [SYMBOL_W-1:0] in_symbol,
   output logic                cmd_valid,
   output cmd_type             cmd,
   input  logic                cmd_pop
);

   cmd_type    slot_ff [2];
   cmd_type    new_cmd;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      new_cmd.pattern = morse_lookup(in_symbol);
      if (in_kind) begin
         new_cmd.op = OP_TICK;
      end else if (in_symbol < SYMBOL_W'(SYMBOL_COUNT)) begin
         new_cmd.op = OP_START;
      end else begin
         new_cmd.op = OP_NOP;
      end
   end

   assign in_ready  = (count_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- rtl/mclk_back.sv -----
`timescale 1ns / 1ps

module mclk_back
   import mclk_pkg::*;
#(
   parameter int TICK_COUNTER_BITS = 20
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [UNIT_TICKS_W-1:0] unit_ticks,
   input  logic                    flight_mode,
   input  logic                    cmd_valid,
   input  cmd_type                 cmd,
   output logic                    cmd_pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic                    out_led,
   output logic                    out_busy
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LIT  = 2'd1;
   localparam logic [1:0] PH_GAP  = 2'd2;
   localparam logic [1:0] PH_END  = 2'd3;

   morse_entry_type              pat_ff, pat_in;
   logic [2:0]                   pos_ff, pos_in;
   logic [1:0]                   phase_ff, phase_in;
   logic [1:0]                   units_ff, units_in;
   logic [TICK_COUNTER_BITS-1:0] tick_ff, tick_in;
   logic [2:0]                   reps_ff, reps_in;
   logic                         busy_ff, busy_in;
   logic                         led_ff, led_in;
   logic                         out_valid_ff, out_valid_in;

   logic [TICK_COUNTER_BITS-1:0] len_raw, unit_len;
   logic [TICK_COUNTER_BITS:0]   tick_next;
   logic                         unit_done;
   logic [1:0]                   units_dec;
   logic [2:0]                   pos_next;
   logic [2:0]                   reps_dec;

   assign cmd_pop   = cmd_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_led   = led_ff;
   assign out_busy  = busy_ff;

   assign len_raw   = TICK_COUNTER_BITS'(unit_ticks);
   assign unit_len  = (len_raw == '0) ? TICK_COUNTER_BITS'(1) : len_raw;
   assign tick_next = {1'b0, tick_ff} + (TICK_COUNTER_BITS + 1)'(1);
   assign unit_done = (tick_next >= {1'b0, unit_len});
   assign units_dec = units_ff - 2'd1;
   assign pos_next  = pos_ff + 3'd1;
   assign reps_dec  = reps_ff - 3'd1;

   function automatic logic is_dash(input morse_entry_type p, input logic [2:0] pos);
      return (pos < 3'(ELEM_MAX)) ? p.dashes[pos] : 1'b0;
   endfunction

   always_comb begin
      pat_in       = pat_ff;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      units_in     = units_ff;
      tick_in      = tick_ff;
      reps_in      = reps_ff;
      busy_in      = busy_ff;
      led_in       = led_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd_pop) begin
         out_valid_in = 1'b1;
         case (cmd.op)
            OP_START: begin
               if (!busy_ff) begin
                  pat_in   = cmd.pattern;
                  pos_in   = 3'd0;
                  tick_in  = '0;
                  reps_in  = flight_mode ? 3'd1 : 3'd5;
                  busy_in  = 1'b1;
                  led_in   = 1'b1;
                  phase_in = PH_LIT;
                  units_in = is_dash(cmd.pattern, 3'd0) ? 2'd3 : 2'd1;
               end
            end
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (!unit_done) begin
                     tick_in = tick_next[TICK_COUNTER_BITS-1:0];
                  end else begin
                     tick_in  = '0;
                     units_in = units_dec;
                     if (units_dec == 2'd0) begin
                        case (phase_ff)
                           PH_LIT: begin
                              led_in   = 1'b0;
                              phase_in = PH_GAP;
                              units_in = 2'd1;
                           end
                           PH_GAP: begin
                              pos_in = pos_next;
                              if (pos_next < pat_ff.len) begin
                                 led_in   = 1'b1;
                                 phase_in = PH_LIT;
                                 units_in = is_dash(pat_ff, pos_next) ? 2'd3 : 2'd1;
                              end else begin
                                 phase_in = PH_END;
                                 units_in = 2'd3;
                              end
                           end
                           default: begin
                              reps_in = reps_dec;
                              if (reps_dec == 3'd0) begin
                                 phase_in = PH_IDLE;
                                 busy_in  = 1'b0;
                                 led_in   = 1'b0;
                              end else begin
                                 pos_in   = 3'd0;
                                 led_in   = 1'b1;
                                 phase_in = PH_LIT;
                                 units_in = is_dash(pat_ff, 3'd0) ? 2'd3 : 2'd1;
                              end
                           end
                        endcase
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         pos_ff       <= 3'd0;
         phase_ff     <= PH_IDLE;
         units_ff     <= 2'd0;
         tick_ff      <= '0;
         reps_ff      <= 3'd0;
         busy_ff      <= 1'b0;
         led_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pat_ff       <= pat_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         units_ff     <= units_in;
         tick_ff      <= tick_in;
         reps_ff      <= reps_in;
         busy_ff      <= busy_in;
         led_ff       <= led_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- rtl/morse_code_led_keyer_core.sv -----
`timescale 1ns / 1ps

// Morse keyer for one LED. Each request beat is either a start (tuser 0,
// symbol index in tdata: letters A-Z as 0-25, digits 1-9 as 26-34, digit 0
// as 35) or one time tick (tuser 1), and each beat produces exactly one
// response beat with the LED level and the busy flag after that beat. A
// dot lights the LED for one unit and a dash for three, each element is
// followed by one dark unit, and a character ends with three more dark
// units; it plays once in flight mode and five times otherwise. A unit
// lasts unit_ticks tick beats, or one if unit_ticks is zero. Starts while
// busy and symbols above 35 are ignored. The block takes one beat per
// clock while rsp_tready stays high: a two-entry command queue after the
// decoder feeds a sequencer whose response register is reloaded in the
// same cycle it is taken, so a request passes the queue slot and then
// the response register on its way to the response.
module morse_code_led_keyer_core
   import mclk_pkg::*;
#(
   parameter int TICK_COUNTER_BITS = 20
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // symbol[5:0], zero pad
   input  logic                    req_tuser,   // kind
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // led, busy_res, zero pad
   input  logic                    csr_we,
   input  logic                    csr_addr,
   input  logic [UNIT_TICKS_W-1:0] csr_wdata
);

   logic [UNIT_TICKS_W-1:0] unit_ticks_ff, unit_ticks_in;
   logic                    flight_ff, flight_in;
   logic                    cmd_valid, cmd_pop;
   cmd_type                 cmd;
   logic                    led, busy;

   always_comb begin
      unit_ticks_in = unit_ticks_ff;
      flight_in     = flight_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_UNIT_TICKS:  unit_ticks_in = csr_wdata;
            CSR_FLIGHT_MODE: flight_in     = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_TICKS_RESET;
         flight_ff     <= 1'b0;
      end else begin
         unit_ticks_ff <= unit_ticks_in;
         flight_ff     <= flight_in;
      end
   end

   mclk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .in_symbol (req_tdata[SYMBOL_W-1:0]),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   mclk_back #(
      .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .unit_ticks  (unit_ticks_ff),
      .flight_mode (flight_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_led     (led),
      .out_busy    (busy)
   );

   assign rsp_tdata = {6'b0, busy, led};

endmodule
